[rtl/lsbse_pkg.sv]
// shared types, constants and helper functions of the two-layer lsb embedder
`timescale 1ns / 1ps
`default_nettype none

package lsbse_pkg;

	localparam int MAX_MSG_BYTES_DEF = 1024;
	localparam int TOTAL_W           = 26;
	localparam int MARK_LEN          = 9;
	localparam int HEADER_BITS       = 16;
	localparam int Q_DEPTH           = 4;
	localparam int Q_CNT_W           = $clog2(Q_DEPTH + 1);
	localparam int APB_AW            = 3;

	localparam logic [APB_AW-1:0] ADDR_CHANNEL_TOTAL = 3'h0;

	localparam logic KIND_MESSAGE = 1'b0;
	localparam logic KIND_CHANNEL = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SMALL = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RG_PASS,
		RG_MARK,
		RG_EMBED
	} region_t;

	typedef enum logic [1:0] {
		B0_KEEP,
		B0_HDR,
		B0_MSG
	} b0_src_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]        channel_value;
		logic [1:0]        status;
		logic              last;
	} result_t;

	// settings derived from channel_total, worked out when the register is written
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] safe;
		logic [TOTAL_W:0]   kbase;
		logic [TOTAL_W:0]   cap;
		logic [TOTAL_W-1:0] last_lim;
		logic               too_small;
	} cfg_t;

	// classified channel request handed from front to back
	typedef struct packed {
		logic [7:0]        data_byte;
		status_t           status;
		logic              last;
		region_t           region;
		logic [3:0]        wm_idx;
		b0_src_t           b0_src;
		logic              hdr_bit;
		logic [2:0]        b0_pos;
		logic              b1_use;
		logic [2:0]        b1_pos;
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [7:0]        msg0;
		logic [7:0]        msg1;
	} entry_t;

	function automatic cfg_t cfg_derive(input logic [TOTAL_W-1:0] total);
		cfg_t c;
		c.total     = total;
		c.safe      = total - TOTAL_W'(MARK_LEN);
		c.kbase     = {1'b0, total} - (TOTAL_W+1)'(MARK_LEN + HEADER_BITS);
		c.cap       = {total, 1'b0} - (TOTAL_W+1)'(2 * MARK_LEN + HEADER_BITS);
		c.last_lim  = (total == '0) ? '0 : total - TOTAL_W'(1);
		c.too_small = total < TOTAL_W'(MARK_LEN + HEADER_BITS + 1);
		return c;
	endfunction

	localparam cfg_t CFG_RESET = cfg_derive(TOTAL_W'(3));

	// watermark byte by distance from the first marked channel
	function automatic logic [7:0] wm_byte(input logic [3:0] d);
		logic [7:0] b;
		unique case (d)
			4'd0:    b = 8'h65;
			4'd1:    b = 8'h6E;
			4'd2:    b = 8'h69;
			4'd3:    b = 8'h67;
			4'd4:    b = 8'h61;
			4'd5:    b = 8'h6D;
			4'd6:    b = 8'h45;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/lsbse_stream_if.sv]
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps
`default_nettype none

interface lsbse_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/lsbse_ram.sv]
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module lsbse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

[rtl/lsbse_front.sv]
// front end: buffers message bytes, classifies channel bytes and fetches their message bits
`timescale 1ns / 1ps
`default_nettype none

module lsbse_front import lsbse_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   cfg_we,
	input  cfg_t   cfg_next,
	input  logic   item_acc,
	input  item_t  item_in,
	output logic   push,
	output entry_t entry
);

	localparam int AW    = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
	localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [3:0] HDR_MSB = 4'(HEADER_BITS - 1);

	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [TOTAL_W-1:0] c_q;
	logic [TOTAL_W:0]   k1_q;
	logic               s1_v_q;
	cls_t               cls_s1;

	logic               msg_acc;
	logic               pix_acc;
	logic               room;
	logic [15:0]        bits16;
	logic [TOTAL_W-1:0] k0;
	logic [TOTAL_W:0]   diff;
	logic               last;
	logic               over;
	cls_t               cls_next;
	logic [7:0]         rd0;
	logic [7:0]         rd1;

	assign msg_acc = item_acc && (item_in.kind == KIND_MESSAGE);
	assign pix_acc = item_acc && (item_in.kind == KIND_CHANNEL);
	assign room    = count_q < CNT_W'(MAX_MESSAGE_BYTES);
	assign bits16  = 16'({count_q, 3'b000});
	assign k0      = c_q - TOTAL_W'(HEADER_BITS);
	assign diff    = {1'b0, c_q} - {1'b0, cfg.safe};
	assign last    = c_q >= cfg.last_lim;
	assign over    = ovf_q || ((TOTAL_W+1)'(bits16) > cfg.cap);

	always_comb begin
		cls_next           = '0;
		cls_next.data_byte = item_in.data_byte;
		cls_next.last      = last;
		cls_next.status    = ST_OK;
		cls_next.region    = RG_PASS;
		cls_next.b0_src    = B0_KEEP;
		cls_next.wm_idx    = diff[3:0];
		cls_next.hdr_bit   = bits16[HDR_MSB - c_q[3:0]];
		cls_next.b0_pos    = ~k0[2:0];
		cls_next.b1_pos    = ~k1_q[2:0];
		cls_next.b1_use    = k1_q < (TOTAL_W+1)'(bits16);
		if (cfg.too_small) begin
			cls_next.status = ST_TOO_SMALL;
		end else if (over) begin
			cls_next.status = ST_TOO_LONG;
		end else if (!diff[TOTAL_W]) begin
			// watermark only up to the true final channel
			if (diff[TOTAL_W-1:0] < TOTAL_W'(MARK_LEN)) begin
				cls_next.region = RG_MARK;
			end
		end else begin
			cls_next.region = RG_EMBED;
			if (c_q < TOTAL_W'(HEADER_BITS)) begin
				cls_next.b0_src = B0_HDR;
			end else if (k0 < TOTAL_W'(bits16)) begin
				cls_next.b0_src = B0_MSG;
			end
		end
	end

	lsbse_ram #(
		.WIDTH (8),
		.DEPTH (MAX_MESSAGE_BYTES)
	) u_store (
		.clk     (clk),
		.we      (msg_acc && room),
		.waddr   (count_q[AW-1:0]),
		.wdata   (item_in.data_byte),
		.re      (pix_acc),
		.raddr_a (k0[AW+2:3]),
		.raddr_b (k1_q[AW+2:3]),
		.rdata_a (rd0),
		.rdata_b (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			c_q     <= '0;
			k1_q    <= CFG_RESET.kbase;
			s1_v_q  <= 1'b0;
		end else begin
			s1_v_q <= pix_acc;
			if (cfg_we) begin
				// keep the second-layer bit index in step with the channel count
				k1_q <= cfg_next.kbase + (TOTAL_W+1)'(c_q);
			end
			if (msg_acc) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (pix_acc) begin
				if (last) begin
					c_q     <= '0;
					k1_q    <= cfg.kbase;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					c_q  <= c_q + TOTAL_W'(1);
					k1_q <= k1_q + (TOTAL_W+1)'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cls_s1 <= cls_next;
		end
	end

	assign push  = s1_v_q;
	assign entry = '{cls: cls_s1, msg0: rd0, msg1: rd1};

endmodule

`default_nettype wire

[rtl/lsbse_queue.sv]
// short fifo of classified channel requests between front and back
`timescale 1ns / 1ps
`default_nettype none

module lsbse_queue import lsbse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  entry_t             wdata,
	input  logic               pop,
	output entry_t             rdata,
	output logic               full,
	output logic               empty,
	output logic [Q_CNT_W-1:0] count
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	entry_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign empty = count_q == '0;
	assign count = count_q;

endmodule

`default_nettype wire

[rtl/lsbse_back.sv]
// back end: builds the rewritten channel byte and holds it in the output register
`timescale 1ns / 1ps
`default_nettype none

module lsbse_back import lsbse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  entry_t  head,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_payload
);

	logic    out_v_q;
	result_t res_q;
	logic    b0;
	logic [7:0] val;

	assign pop = !q_empty && (!out_v_q || out_ready);

	always_comb begin
		unique case (head.cls.b0_src)
			B0_HDR:  b0 = head.cls.hdr_bit;
			B0_MSG:  b0 = head.msg0[head.cls.b0_pos];
			default: b0 = head.cls.data_byte[0];
		endcase
		unique case (head.cls.region)
			RG_MARK: begin
				val = wm_byte(head.cls.wm_idx);
			end
			RG_EMBED: begin
				val = {head.cls.data_byte[7:1], b0};
				if (head.cls.b1_use) begin
					val[1] = head.msg1[head.cls.b1_pos];
				end
			end
			default: begin
				val = head.cls.data_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.channel_value <= val;
			res_q.status        <= head.cls.status;
			res_q.last          <= head.cls.last;
		end
	end

	assign out_valid   = out_v_q;
	assign out_payload = res_q;

endmodule

`default_nettype wire

[rtl/lsb_two_layer_stego_embed_unit.sv]
// Two-layer lsb embedder top level: config port, front end, request queue, back end.
// One item per cycle while the queue has room, message byte or channel byte, set by the
// single front stage that classifies a channel and reads its two message bits. A
// channel result passes the front register, queue and output register; message bytes
// give no result. Reset clears counters, flags and queue at once and sets channel_total
// to 3; the message buffer keeps no reset and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lsb_two_layer_stego_embed_unit import lsbse_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lsbse_stream_if.sink      item,
	lsbse_stream_if.source    result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t               cfg_q;
	cfg_t               cfg_next;
	logic               reg_hit;
	logic               cfg_we;
	logic               item_acc;
	logic               push;
	entry_t             push_entry;
	logic               pop;
	entry_t             head;
	logic               q_full;
	logic               q_empty;
	logic [Q_CNT_W-1:0] q_count;

	assign pready   = 1'b1;
	assign reg_hit  = paddr[APB_AW-1:2] == ADDR_CHANNEL_TOTAL[APB_AW-1:2];
	assign cfg_we   = psel && penable && pwrite && pready && reg_hit;
	assign cfg_next = cfg_derive(pwdata[TOTAL_W-1:0]);
	assign prdata   = reg_hit ? 32'(cfg_q.total) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_next;
		end
	end

	// leave room in the queue for the request still in the front stage
	assign item.ready = ({1'b0, q_count} + (Q_CNT_W+1)'(push)) < (Q_CNT_W+1)'(Q_DEPTH);
	assign item_acc   = item.valid && item.ready;

	lsbse_front #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_we   (cfg_we),
		.cfg_next (cfg_next),
		.item_acc (item_acc),
		.item_in  (item.payload),
		.push     (push),
		.entry    (push_entry)
	);

	lsbse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty),
		.count  (q_count)
	);

	lsbse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_payload (result.payload)
	);

`ifndef NO_ASSERTIONS
	a_no_queue_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into a full queue");

	a_small_matches_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.status == ST_TOO_SMALL) |-> cfg_q.too_small)
		else $error("too-small status while image size is adequate");

	a_small_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.status == ST_TOO_LONG) |-> !cfg_q.too_small)
		else $error("too-long status given although image is too small");
`endif

endmodule

`default_nettype wire
